[rtl/qhp_pkg.sv]
package qhp_pkg;

    // Width of the byte and payload counters; both saturate at the top value.
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Decoded variable-length integers are 62 bits wide.
    localparam int VARINT_BITS = 62;

    // Result status codes.
    localparam logic [2:0] ST_COMPLETE    = 3'd0;
    localparam logic [2:0] ST_NOT_QUIC    = 3'd1;
    localparam logic [2:0] ST_TRUNCATED   = 3'd2;
    localparam logic [2:0] ST_ID_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_VERSION_NEG = 3'd4;
    localparam logic [2:0] ST_RETRY       = 3'd5;

    // Content hint codes.
    localparam logic [2:0] HINT_NONE         = 3'd0;
    localparam logic [2:0] HINT_CLIENT_HELLO = 3'd1;
    localparam logic [2:0] HINT_SERVER_HELLO = 3'd2;
    localparam logic [2:0] HINT_CERTIFICATE  = 3'd3;
    localparam logic [2:0] HINT_ENCRYPTED    = 3'd4;

    // Long header packet types.
    localparam logic [1:0] TYPE_INITIAL   = 2'd0;
    localparam logic [1:0] TYPE_ZERO_RTT  = 2'd1;
    localparam logic [1:0] TYPE_HANDSHAKE = 2'd2;
    localparam logic [1:0] TYPE_RETRY     = 2'd3;

    // Versions that pass detection.
    localparam logic [31:0] VERSION_1        = 32'h0000_0001;
    localparam logic [31:0] VERSION_DRAFT29  = 32'hff00_001d;
    localparam logic [31:0] VERSION_NEG      = 32'h0000_0000;
    localparam logic [31:0] VERSION_V2_DRAFT = 32'h6b33_43cf;
    localparam logic [31:0] VERSION_Q050     = 32'h5130_3530;
    localparam logic [31:0] VERSION_Q046     = 32'h5130_3436;
    localparam logic [31:0] VERSION_TOP_MASK = 32'hFF00_0000;

    // TLS handshake message types at the head of the payload.
    localparam logic [15:0] TLS_CLIENT_HELLO = 16'h0100;
    localparam logic [15:0] TLS_SERVER_HELLO = 16'h0200;
    localparam logic [15:0] TLS_CERTIFICATE  = 16'h0b00;

    localparam logic [4:0] MAX_CID_RESET = 5'd20;

    // One header summary.
    typedef struct packed {
        logic                   detected;
        logic [7:0]             header_byte;
        logic [31:0]            version_word;
        logic [7:0]             dest_id_length;
        logic [7:0]             source_id_length;
        logic [VARINT_BITS-1:0] token_length;
        logic [VARINT_BITS-1:0] length_field;
        logic [31:0]            packet_number;
        logic [15:0]            payload_bytes;
        logic [2:0]             content_hint;
        logic [2:0]             status;
    } result_t;

endpackage

[rtl/quic_header_parser_top.sv]
// QUIC packet header parser.
// The input channel carries one UDP payload byte per transaction, with
// last_byte marking the final byte of a packet. Every byte updates the
// parser state in the cycle it is accepted; the final byte also produces
// one header summary on the output channel.
// Throughput is one byte per clock cycle while in_stall is low;
// back-to-back packets need no gap between them.
// Each summary is registered into the result register or the skid buffer.
// The output side holds a result register and a one-entry skid buffer, so
// bytes keep flowing while a summary waits; in_stall rises only when both
// are full, and falls as soon as the receiver takes one.
// The max_cid_reg register resets to 20; the user must write it through
// cfg_write_en and cfg_write_data only while the block is idle; the block does not enforce this.
// Reset (rst_n low, asynchronous) returns the parser to the first byte of
// a packet and empties the output buffers.
// A stalled summary stays unchanged on the outputs until out_stall is low.
module quic_header_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [4:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        detected,
    output logic [7:0]  header_byte,
    output logic [31:0] version_word,
    output logic [7:0]  dest_id_length,
    output logic [7:0]  source_id_length,
    output logic [61:0] token_length,
    output logic [61:0] length_field,
    output logic [31:0] packet_number,
    output logic [15:0] payload_bytes,
    output logic [2:0]  content_hint,
    output logic [2:0]  status
);

    localparam int CB = qhp_pkg::COUNT_BITS;
    localparam int VB = qhp_pkg::VARINT_BITS;

    typedef enum logic [3:0] {
        PH_FIRST, PH_VERSION, PH_DLEN, PH_DSKIP, PH_SLEN, PH_SSKIP,
        PH_TOKV0, PH_TOKV, PH_TOKSKIP, PH_LENV0, PH_LENV, PH_PN,
        PH_PAYLOAD, PH_DONE
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [CB-1:0]   byte_count_reg, byte_count_next;
    logic [7:0]      first_byte_reg, first_byte_next;
    logic [31:0]     version_reg, version_next;
    logic [7:0]      dest_len_reg, dest_len_next;
    logic [7:0]      source_len_reg, source_len_next;
    logic [VB-1:0]   accum_reg, accum_next;
    logic [VB-1:0]   countdown_reg, countdown_next;
    logic [VB-1:0]   token_len_reg, token_len_next;
    logic [VB-1:0]   length_reg, length_next;
    logic [31:0]     number_reg, number_next;
    logic [15:0]     payload_head_reg, payload_head_next;
    logic [CB-1:0]   payload_count_reg, payload_count_next;
    logic [2:0]      status_reg, status_next;
    logic [4:0]      max_cid_reg;

    qhp_pkg::result_t out_reg, skid_reg, result;
    logic             out_valid_reg, skid_valid_reg;

    logic in_accept;
    logic new_result;
    logic out_take;

    assign in_accept  = in_valid && !in_stall;
    assign new_result = in_accept && last_byte;
    assign out_take   = out_valid_reg && !out_stall;
    assign in_stall   = skid_valid_reg;

    // Per-byte parser step.
    always_comb
    begin
        logic [VB-1:0] dec;
        logic [VB-1:0] acc;
        logic          acc_done;
        logic          rest_phase;
        logic          tok_varint;

        phase_next         = phase_reg;
        first_byte_next    = first_byte_reg;
        version_next       = version_reg;
        dest_len_next      = dest_len_reg;
        source_len_next    = source_len_reg;
        accum_next         = accum_reg;
        countdown_next     = countdown_reg;
        token_len_next     = token_len_reg;
        length_next        = length_reg;
        number_next        = number_reg;
        payload_head_next  = payload_head_reg;
        payload_count_next = payload_count_reg;
        status_next        = status_reg;

        dec        = countdown_reg - VB'(1);
        acc        = '0;
        acc_done   = 1'b0;
        rest_phase = 1'b0;
        tok_varint = (phase_reg == PH_TOKV0) || (phase_reg == PH_TOKV);

        case (phase_reg)
            PH_FIRST:
            begin
                first_byte_next = data_byte;
                if (data_byte[7])
                begin
                    countdown_next = VB'(4);
                    phase_next     = PH_VERSION;
                end
                else
                begin
                    countdown_next = VB'(data_byte[1:0]) + VB'(1);
                    phase_next     = PH_PN;
                end
            end
            PH_VERSION:
            begin
                version_next   = {version_reg[23:0], data_byte};
                countdown_next = dec;
                if (dec == '0)
                begin
                    if (version_next == qhp_pkg::VERSION_NEG)
                    begin
                        status_next = qhp_pkg::ST_VERSION_NEG;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_DLEN;
                    end
                end
            end
            PH_DLEN, PH_SLEN:
            begin
                if (phase_reg == PH_DLEN)
                    dest_len_next = data_byte;
                else
                    source_len_next = data_byte;
                if (data_byte > {3'b000, max_cid_reg})
                begin
                    status_next = qhp_pkg::ST_ID_TOO_LONG;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    countdown_next = VB'(data_byte);
                    if (data_byte != 8'd0)
                        phase_next = (phase_reg == PH_DLEN) ? PH_DSKIP : PH_SSKIP;
                    else if (phase_reg == PH_DLEN)
                        phase_next = PH_SLEN;
                    else
                        rest_phase = 1'b1;
                end
            end
            PH_DSKIP, PH_SSKIP:
            begin
                countdown_next = dec;
                if (dec == '0)
                begin
                    if (phase_reg == PH_DSKIP)
                        phase_next = PH_SLEN;
                    else
                        rest_phase = 1'b1;
                end
            end
            PH_TOKV0, PH_LENV0:
            begin
                acc = VB'(data_byte[5:0]);
                accum_next = acc;
                if (data_byte[7:6] == 2'd0)
                begin
                    acc_done = 1'b1;
                end
                else
                begin
                    countdown_next = (data_byte[7:6] == 2'd1) ? VB'(1) :
                                     (data_byte[7:6] == 2'd2) ? VB'(3) : VB'(7);
                    phase_next = (phase_reg == PH_TOKV0) ? PH_TOKV : PH_LENV;
                end
            end
            PH_TOKV, PH_LENV:
            begin
                acc            = {accum_reg[VB-9:0], data_byte};
                accum_next     = acc;
                countdown_next = dec;
                acc_done       = (dec == '0);
            end
            PH_TOKSKIP:
            begin
                countdown_next = dec;
                if (dec == '0)
                    phase_next = PH_LENV0;
            end
            PH_PN:
            begin
                number_next    = {number_reg[23:0], data_byte};
                countdown_next = dec;
                if (dec == '0)
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (payload_count_reg < CB'(2))
                    payload_head_next = {payload_head_reg[7:0], data_byte};
                if (payload_count_reg != qhp_pkg::CNT_MAX)
                    payload_count_next = payload_count_reg + CB'(1);
            end
            default:
            begin
            end
        endcase

        // Connection IDs done: choose by packet type.
        if (rest_phase)
        begin
            case (first_byte_reg[5:4])
                qhp_pkg::TYPE_INITIAL: phase_next = PH_TOKV0;
                qhp_pkg::TYPE_RETRY:
                begin
                    status_next = qhp_pkg::ST_RETRY;
                    phase_next  = PH_DONE;
                end
                default:               phase_next = PH_LENV0;
            endcase
        end

        // A varint is complete.
        if (acc_done)
        begin
            if (tok_varint)
            begin
                token_len_next = acc;
                if (acc != '0)
                begin
                    countdown_next = acc;
                    phase_next     = PH_TOKSKIP;
                end
                else
                begin
                    phase_next = PH_LENV0;
                end
            end
            else
            begin
                length_next    = acc;
                countdown_next = VB'(first_byte_reg[1:0]) + VB'(1);
                phase_next     = PH_PN;
            end
        end

        byte_count_next = (byte_count_reg != qhp_pkg::CNT_MAX) ?
                          byte_count_reg + CB'(1) : byte_count_reg;
    end

    // Header summary built from the state after the final byte.
    always_comb
    begin
        logic       lng;
        logic       det;
        logic [2:0] st;
        logic [2:0] hint;

        lng = first_byte_next[7];
        if (byte_count_next < CB'(5))
            det = 1'b0;
        else if (lng)
            det = (byte_count_next >= CB'(6)) &&
                  ((version_next == qhp_pkg::VERSION_1) ||
                   (version_next == qhp_pkg::VERSION_DRAFT29) ||
                   (version_next == qhp_pkg::VERSION_NEG) ||
                   (version_next == qhp_pkg::VERSION_V2_DRAFT) ||
                   (version_next == qhp_pkg::VERSION_Q050) ||
                   (version_next == qhp_pkg::VERSION_Q046) ||
                   ((version_next & qhp_pkg::VERSION_TOP_MASK) ==
                    qhp_pkg::VERSION_TOP_MASK));
        else
            det = first_byte_next[6] &&
                  (byte_count_next > (CB'(first_byte_next[1:0]) + CB'(5)));

        if (phase_next == PH_DONE)
            st = status_next;
        else if (phase_next == PH_PAYLOAD)
            st = qhp_pkg::ST_COMPLETE;
        else
            st = qhp_pkg::ST_TRUNCATED;

        hint = qhp_pkg::HINT_NONE;
        if (st == qhp_pkg::ST_COMPLETE)
        begin
            if (!lng || (first_byte_next[5:4] == qhp_pkg::TYPE_ZERO_RTT))
                hint = qhp_pkg::HINT_ENCRYPTED;
            else if (payload_count_next > CB'(4))
            begin
                if (payload_head_next == qhp_pkg::TLS_CLIENT_HELLO)
                    hint = qhp_pkg::HINT_CLIENT_HELLO;
                else if (payload_head_next == qhp_pkg::TLS_SERVER_HELLO)
                    hint = qhp_pkg::HINT_SERVER_HELLO;
                else if (payload_head_next == qhp_pkg::TLS_CERTIFICATE)
                    hint = qhp_pkg::HINT_CERTIFICATE;
            end
        end

        result = '0;
        if (!det)
        begin
            result.status = qhp_pkg::ST_NOT_QUIC;
        end
        else
        begin
            result.detected         = 1'b1;
            result.header_byte      = first_byte_next;
            result.version_word     = lng ? version_next : 32'd0;
            result.dest_id_length   = dest_len_next;
            result.source_id_length = source_len_next;
            result.token_length     = token_len_next;
            result.length_field     = length_next;
            result.packet_number    = number_next;
            result.payload_bytes    = 16'(payload_count_next);
            result.content_hint     = hint;
            result.status           = st;
        end
    end

    // Parser state, configuration and output buffers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_FIRST;
            byte_count_reg    <= '0;
            first_byte_reg    <= '0;
            version_reg       <= '0;
            dest_len_reg      <= '0;
            source_len_reg    <= '0;
            accum_reg         <= '0;
            countdown_reg     <= '0;
            token_len_reg     <= '0;
            length_reg        <= '0;
            number_reg        <= '0;
            payload_head_reg  <= '0;
            payload_count_reg <= '0;
            status_reg        <= '0;
            max_cid_reg       <= qhp_pkg::MAX_CID_RESET;
            out_reg           <= '0;
            skid_reg          <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                max_cid_reg <= cfg_write_data;

            if (in_accept)
            begin
                if (last_byte)
                begin
                    phase_reg         <= PH_FIRST;
                    byte_count_reg    <= '0;
                    first_byte_reg    <= '0;
                    version_reg       <= '0;
                    dest_len_reg      <= '0;
                    source_len_reg    <= '0;
                    accum_reg         <= '0;
                    countdown_reg     <= '0;
                    token_len_reg     <= '0;
                    length_reg        <= '0;
                    number_reg        <= '0;
                    payload_head_reg  <= '0;
                    payload_count_reg <= '0;
                    status_reg        <= '0;
                end
                else
                begin
                    phase_reg         <= phase_next;
                    byte_count_reg    <= byte_count_next;
                    first_byte_reg    <= first_byte_next;
                    version_reg       <= version_next;
                    dest_len_reg      <= dest_len_next;
                    source_len_reg    <= source_len_next;
                    accum_reg         <= accum_next;
                    countdown_reg     <= countdown_next;
                    token_len_reg     <= token_len_next;
                    length_reg        <= length_next;
                    number_reg        <= number_next;
                    payload_head_reg  <= payload_head_next;
                    payload_count_reg <= payload_count_next;
                    status_reg        <= status_next;
                end
            end

            // Result register with a one-entry skid buffer behind it.
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (new_result)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_reg       <= result;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= result;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign detected         = out_reg.detected;
    assign header_byte      = out_reg.header_byte;
    assign version_word     = out_reg.version_word;
    assign dest_id_length   = out_reg.dest_id_length;
    assign source_id_length = out_reg.source_id_length;
    assign token_length     = out_reg.token_length;
    assign length_field     = out_reg.length_field;
    assign packet_number    = out_reg.packet_number;
    assign payload_bytes    = out_reg.payload_bytes;
    assign content_hint     = out_reg.content_hint;
    assign status           = out_reg.status;

`ifndef SYNTHESIS
    // The skid buffer is only ever filled behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a result while the output is empty");

    // A stalled result is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

    // The final byte returns the parser to the start of a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> (phase_reg == PH_FIRST && byte_count_reg == '0))
        else $error("packet state not cleared after final byte");

    // An early end always carries one of the early-end status codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (status_reg == qhp_pkg::ST_ID_TOO_LONG ||
                                    status_reg == qhp_pkg::ST_VERSION_NEG ||
                                    status_reg == qhp_pkg::ST_RETRY))
        else $error("early end without an early-end status");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    // Where the header walk stands within the current packet.
    typedef enum logic [3:0]
    {
        P_FIRST, P_VERSION, P_DLEN, P_DSKIP, P_SLEN, P_SSKIP, P_TOKV0, P_TOKV,
        P_TOKSKIP, P_LENV0, P_LENV, P_PN, P_PAYLOAD, P_DONE
    } walk_phase_t;

    // One pending byte transaction for the input channel.
    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [4:0]  cfg_write_data = 5'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        detected;
    logic [7:0]  header_byte;
    logic [31:0] version_word;
    logic [7:0]  dest_id_length;
    logic [7:0]  source_id_length;
    logic [61:0] token_length;
    logic [61:0] length_field;
    logic [31:0] packet_number;
    logic [15:0] payload_bytes;
    logic [2:0]  content_hint;
    logic [2:0]  status;

    quic_header_parser_top u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .detected         (detected),
        .header_byte      (header_byte),
        .version_word     (version_word),
        .dest_id_length   (dest_id_length),
        .source_id_length (source_id_length),
        .token_length     (token_length),
        .length_field     (length_field),
        .packet_number    (packet_number),
        .payload_bytes    (payload_bytes),
        .content_hint     (content_hint),
        .status           (status)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    byte_item_t       byte_q[$];
    qhp_pkg::result_t summary_q[$];
    logic [7:0]       pkt[$];
    bit               no_idle = 1'b0;
    int unsigned      mismatch_count = 0;
    qhp_pkg::result_t want_sum;

    // Our own copy of the parser state and of the connection ID limit.
    logic [4:0]  cid_limit = qhp_pkg::MAX_CID_RESET;
    walk_phase_t ph = P_FIRST;
    logic [15:0] seen_bytes = '0;
    logic [7:0]  hdr = '0;
    logic [31:0] ver = '0;
    logic [7:0]  dlen = '0;
    logic [7:0]  slen = '0;
    logic [61:0] vacc = '0;
    logic [61:0] countdown = '0;
    logic [61:0] tok_len = '0;
    logic [61:0] len_val = '0;
    logic [31:0] pn_val = '0;
    logic [15:0] pay_head = '0;
    logic [15:0] pay_cnt = '0;
    logic [2:0]  end_status = '0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 40)
            $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    function automatic void clear_packet();
        ph = P_FIRST;
        seen_bytes = '0; hdr = '0; ver = '0; dlen = '0; slen = '0;
        vacc = '0; countdown = '0; tok_len = '0; len_val = '0;
        pn_val = '0; pay_head = '0; pay_cnt = '0; end_status = '0;
    endfunction

    function automatic void end_parse(input logic [2:0] st);
        end_status = st;
        ph = P_DONE;
    endfunction

    function automatic void start_number();
        countdown = {60'd0, hdr[1:0]} + 62'd1;
        ph = P_PN;
    endfunction

    // Both connection IDs are behind us; the packet type decides what follows.
    function automatic void ids_done();
        case (hdr[5:4])
            qhp_pkg::TYPE_INITIAL:
            begin
                ph = P_TOKV0;
            end
            qhp_pkg::TYPE_RETRY:
            begin
                end_parse(qhp_pkg::ST_RETRY);
            end
            default:
            begin
                ph = P_LENV0;
            end
        endcase
    endfunction

    function automatic void varint_complete(input logic is_token);
        if (is_token)
        begin
            tok_len = vacc;
            if (vacc != 62'd0)
            begin
                countdown = vacc;
                ph = P_TOKSKIP;
            end
            else
            begin
                ph = P_LENV0;
            end
        end
        else
        begin
            len_val = vacc;
            start_number();
        end
    endfunction

    // The two top bits of the leading byte give the varint size.
    function automatic void varint_lead(input logic is_token, input logic [7:0] b);
        logic [61:0] extra;
        case (b[7:6])
            2'd0:    extra = 62'd0;
            2'd1:    extra = 62'd1;
            2'd2:    extra = 62'd3;
            default: extra = 62'd7;
        endcase
        vacc = {56'd0, b[5:0]};
        if (extra == 62'd0)
        begin
            varint_complete(is_token);
        end
        else
        begin
            countdown = extra;
            if (is_token)
                ph = P_TOKV;
            else
                ph = P_LENV;
        end
    endfunction

    function automatic void varint_more(input logic is_token, input logic [7:0] b);
        vacc = {vacc[53:0], b};
        countdown = countdown - 62'd1;
        if (countdown == 62'd0)
            varint_complete(is_token);
    endfunction

    function automatic logic passes_detection();
        if (seen_bytes < 16'd5)
            return 1'b0;
        if (hdr[7])
        begin
            if (seen_bytes < 16'd6)
                return 1'b0;
            if (ver == qhp_pkg::VERSION_1 || ver == qhp_pkg::VERSION_DRAFT29 ||
                ver == qhp_pkg::VERSION_NEG || ver == qhp_pkg::VERSION_V2_DRAFT ||
                ver == qhp_pkg::VERSION_Q050 || ver == qhp_pkg::VERSION_Q046)
                return 1'b1;
            return (ver & qhp_pkg::VERSION_TOP_MASK) == qhp_pkg::VERSION_TOP_MASK;
        end
        if (!hdr[6])
            return 1'b0;
        return seen_bytes > ({14'd0, hdr[1:0]} + 16'd5);
    endfunction

    // Advances the header walk by one byte; the final byte queues the summary.
    function automatic void parse_header_byte(input logic [7:0] b, input logic last);
        qhp_pkg::result_t sum;
        case (ph)
            P_FIRST:
            begin
                hdr = b;
                if (b[7])
                begin
                    countdown = 62'd4;
                    ph = P_VERSION;
                end
                else
                begin
                    start_number();
                end
            end
            P_VERSION:
            begin
                ver = {ver[23:0], b};
                countdown = countdown - 62'd1;
                if (countdown == 62'd0)
                begin
                    if (ver == qhp_pkg::VERSION_NEG)
                        end_parse(qhp_pkg::ST_VERSION_NEG);
                    else
                        ph = P_DLEN;
                end
            end
            P_DLEN, P_SLEN:
            begin
                if (ph == P_DLEN)
                    dlen = b;
                else
                    slen = b;
                if (b > {3'd0, cid_limit})
                begin
                    end_parse(qhp_pkg::ST_ID_TOO_LONG);
                end
                else if (b != 8'd0)
                begin
                    countdown = {54'd0, b};
                    if (ph == P_DLEN)
                        ph = P_DSKIP;
                    else
                        ph = P_SSKIP;
                end
                else if (ph == P_DLEN)
                begin
                    ph = P_SLEN;
                end
                else
                begin
                    ids_done();
                end
            end
            P_DSKIP, P_SSKIP:
            begin
                countdown = countdown - 62'd1;
                if (countdown == 62'd0)
                begin
                    if (ph == P_DSKIP)
                        ph = P_SLEN;
                    else
                        ids_done();
                end
            end
            P_TOKV0:
            begin
                varint_lead(1'b1, b);
            end
            P_TOKV:
            begin
                varint_more(1'b1, b);
            end
            P_TOKSKIP:
            begin
                countdown = countdown - 62'd1;
                if (countdown == 62'd0)
                    ph = P_LENV0;
            end
            P_LENV0:
            begin
                varint_lead(1'b0, b);
            end
            P_LENV:
            begin
                varint_more(1'b0, b);
            end
            P_PN:
            begin
                pn_val = {pn_val[23:0], b};
                countdown = countdown - 62'd1;
                if (countdown == 62'd0)
                    ph = P_PAYLOAD;
            end
            P_PAYLOAD:
            begin
                if (pay_cnt < 16'd2)
                    pay_head = {pay_head[7:0], b};
                if (pay_cnt != qhp_pkg::CNT_MAX)
                    pay_cnt = pay_cnt + 16'd1;
            end
            default:
            begin
            end
        endcase
        if (seen_bytes != qhp_pkg::CNT_MAX)
            seen_bytes = seen_bytes + 16'd1;
        if (!last)
            return;

        sum = '0;
        if (!passes_detection())
        begin
            sum.status = qhp_pkg::ST_NOT_QUIC;
        end
        else
        begin
            sum.detected         = 1'b1;
            sum.header_byte      = hdr;
            sum.version_word     = hdr[7] ? ver : 32'd0;
            sum.dest_id_length   = dlen;
            sum.source_id_length = slen;
            sum.token_length     = tok_len;
            sum.length_field     = len_val;
            sum.packet_number    = pn_val;
            sum.payload_bytes    = pay_cnt;
            if (ph == P_DONE)
                sum.status = end_status;
            else if (ph == P_PAYLOAD)
                sum.status = qhp_pkg::ST_COMPLETE;
            else
                sum.status = qhp_pkg::ST_TRUNCATED;
            // The TLS hint is only given for a completely parsed header.
            if (sum.status == qhp_pkg::ST_COMPLETE)
            begin
                if (!hdr[7] || hdr[5:4] == qhp_pkg::TYPE_ZERO_RTT)
                    sum.content_hint = qhp_pkg::HINT_ENCRYPTED;
                else if (pay_cnt > 16'd4)
                begin
                    if (pay_head == qhp_pkg::TLS_CLIENT_HELLO)
                        sum.content_hint = qhp_pkg::HINT_CLIENT_HELLO;
                    else if (pay_head == qhp_pkg::TLS_SERVER_HELLO)
                        sum.content_hint = qhp_pkg::HINT_SERVER_HELLO;
                    else if (pay_head == qhp_pkg::TLS_CERTIFICATE)
                        sum.content_hint = qhp_pkg::HINT_CERTIFICATE;
                end
            end
        end
        summary_q.push_back(sum);
        clear_packet();
    endfunction

    // Packet assembly helpers; bytes gather in pkt before being queued.
    function automatic void add_random_bytes(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            pkt.push_back(8'($urandom_range(255)));
    endfunction

    function automatic int unsigned pick_varint_size();
        case ($urandom_range(3))
            0:       return 1;
            1:       return 2;
            2:       return 4;
            default: return 8;
        endcase
    endfunction

    function automatic void add_varint(input logic [63:0] value, input int unsigned n);
        logic [63:0] word;
        logic [63:0] code;
        int          i;
        case (n)
            1:       code = 64'd0;
            2:       code = 64'd1;
            4:       code = 64'd2;
            default: code = 64'd3;
        endcase
        word = (value & ((64'd1 << (8 * n - 2)) - 64'd1)) | (code << (8 * n - 2));
        for (i = int'(n) - 1; i >= 0; i--)
            pkt.push_back(word[8 * i +: 8]);
    endfunction

    // Payload that often opens with one of the TLS handshake message types.
    function automatic void add_payload();
        int unsigned n;
        n = $urandom_range(9);
        if (n >= 2)
        begin
            case ($urandom_range(3))
                0:
                begin
                    pkt.push_back(qhp_pkg::TLS_CLIENT_HELLO[15:8]);
                    pkt.push_back(qhp_pkg::TLS_CLIENT_HELLO[7:0]);
                end
                1:
                begin
                    pkt.push_back(qhp_pkg::TLS_SERVER_HELLO[15:8]);
                    pkt.push_back(qhp_pkg::TLS_SERVER_HELLO[7:0]);
                end
                2:
                begin
                    pkt.push_back(qhp_pkg::TLS_CERTIFICATE[15:8]);
                    pkt.push_back(qhp_pkg::TLS_CERTIFICATE[7:0]);
                end
                default:
                begin
                    add_random_bytes(2);
                end
            endcase
            add_random_bytes(n - 2);
        end
        else
        begin
            add_random_bytes(n);
        end
    endfunction

    function automatic void build_short_packet();
        logic [7:0] first;
        first = 8'($urandom_range(255));
        first[7] = 1'b0;
        if ($urandom_range(7) != 0)
            first[6] = 1'b1;
        pkt.push_back(first);
        add_random_bytes({30'd0, first[1:0]} + 32'd1);
        add_payload();
    endfunction

    function automatic void build_long_packet();
        logic [7:0]  first;
        logic [31:0] version;
        logic [7:0]  id_len;
        logic [63:0] token_val;
        int unsigned pick;
        int          i;
        first = 8'($urandom_range(255));
        first[7] = 1'b1;
        pick = $urandom_range(9);
        if (pick < 4)
            first[5:4] = qhp_pkg::TYPE_INITIAL;
        else if (pick < 6)
            first[5:4] = qhp_pkg::TYPE_HANDSHAKE;
        else if (pick < 8)
            first[5:4] = qhp_pkg::TYPE_ZERO_RTT;
        else
            first[5:4] = qhp_pkg::TYPE_RETRY;
        pkt.push_back(first);

        case ($urandom_range(13))
            2:       version = qhp_pkg::VERSION_DRAFT29;
            3:       version = qhp_pkg::VERSION_V2_DRAFT;
            4:       version = qhp_pkg::VERSION_Q050;
            5:       version = qhp_pkg::VERSION_Q046;
            6:       version = {8'hFF, 24'($urandom)};
            7:       version = qhp_pkg::VERSION_NEG;
            8:       version = $urandom;
            default: version = qhp_pkg::VERSION_1;
        endcase
        for (i = 0; i < 4; i++)
            pkt.push_back(version[31 - 8 * i -: 8]);

        // Destination then source ID, now and then longer than the limit.
        repeat (2)
        begin
            if ($urandom_range(11) == 0)
            begin
                id_len = 8'($urandom_range(255, {27'd0, cid_limit} + 32'd1));
                pkt.push_back(id_len);
                add_random_bytes($urandom_range(3));
                return;
            end
            id_len = 8'($urandom_range({27'd0, cid_limit}));
            pkt.push_back(id_len);
            add_random_bytes({24'd0, id_len});
        end

        if (first[5:4] == qhp_pkg::TYPE_INITIAL)
        begin
            if ($urandom_range(11) == 0)
            begin
                // A huge token that the packet never gets to the end of.
                token_val = {$urandom, $urandom};
                add_varint(token_val, 8);
                add_random_bytes($urandom_range(6));
                return;
            end
            token_val = 64'($urandom_range(4));
            add_varint(token_val, pick_varint_size());
            add_random_bytes(32'(token_val));
        end
        add_varint({$urandom, $urandom}, pick_varint_size());
        add_random_bytes({30'd0, first[1:0]} + 32'd1);
        add_payload();
    endfunction

    function automatic void send_packet(input int unsigned n);
        byte_item_t  item;
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            item.data = pkt[i];
            item.last = (i == n - 1);
            byte_q.push_back(item);
        end
    endfunction

    // Mostly well-formed headers, some short ones, noise and cut packets.
    function automatic int unsigned queue_random_packet();
        int unsigned pick;
        int unsigned n;
        pkt.delete();
        pick = $urandom_range(9);
        if (pick == 0)
            add_random_bytes($urandom_range(8, 1));
        else if (pick < 4)
            build_short_packet();
        else
            build_long_packet();
        n = pkt.size();
        if ($urandom_range(5) == 0)
            n = $urandom_range(n, 1);
        send_packet(n);
        return n;
    endfunction

    // Lets the input drain and the last summary arrive, then idles on.
    task automatic wait_quiet();
        int unsigned guard;
        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        guard = 0;
        while (summary_q.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cid_limit(input logic [4:0] value);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cid_limit = value;
    endtask

    // Input driver: holds a stalled transaction, otherwise sends or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'd0;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_header_byte(data_byte, last_byte);
                void'(byte_q.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (byte_q.size() != 0 && (no_idle || $urandom_range(99) >= 32))
                begin
                    in_valid  <= 1'b1;
                    data_byte <= byte_q[0].data;
                    last_byte <= byte_q[0].last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each summary against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (summary_q.size() == 0)
                begin
                    report_mismatch("summary with none expected", 64'd0, 64'd0);
                end
                else
                begin
                    want_sum = summary_q.pop_front();
                    check_field("detected", 64'(detected), 64'(want_sum.detected));
                    check_field("header_byte", 64'(header_byte),
                                64'(want_sum.header_byte));
                    check_field("version_word", 64'(version_word),
                                64'(want_sum.version_word));
                    check_field("dest_id_length", 64'(dest_id_length),
                                64'(want_sum.dest_id_length));
                    check_field("source_id_length", 64'(source_id_length),
                                64'(want_sum.source_id_length));
                    check_field("token_length", 64'(token_length),
                                64'(want_sum.token_length));
                    check_field("length_field", 64'(length_field),
                                64'(want_sum.length_field));
                    check_field("packet_number", 64'(packet_number),
                                64'(want_sum.packet_number));
                    check_field("payload_bytes", 64'(payload_bytes),
                                64'(want_sum.payload_bytes));
                    check_field("content_hint", 64'(content_hint),
                                64'(want_sum.content_hint));
                    check_field("status", 64'(status), 64'(want_sum.status));
                end
            end
            out_stall <= !no_idle && ($urandom_range(99) < 32);
        end
    end

    // Stimulus sequence.
    initial
    begin
        int unsigned phase_bytes;
        int          p;
        bit          paused;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Too short for a short header.
        pkt = '{8'h43, 8'hFF, 8'hFF, 8'hFF};
        send_packet(pkt.size());
        // Version negotiation.
        pkt = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05};
        send_packet(pkt.size());
        // Retry ends once the source ID is done.
        pkt = '{8'hF0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'hAA};
        send_packet(pkt.size());
        // Destination ID length far above the limit.
        pkt = '{8'hC0, 8'hFF, 8'h00, 8'h00, 8'h1D, 8'hFF};
        send_packet(pkt.size());

        paused = 1'b0;
        for (p = 0; p < 5; p++)
        begin
            if (p != 0)
            begin
                wait_quiet();
                case (p)
                    1:       write_cid_limit(5'd0);
                    2:       write_cid_limit(5'd31);
                    3:       write_cid_limit(5'($urandom_range(31)));
                    default: write_cid_limit(qhp_pkg::MAX_CID_RESET);
                endcase
            end
            no_idle = (p == 2);
            phase_bytes = 0;
            while (phase_bytes < 90)
            begin
                phase_bytes += queue_random_packet();
                // The sender holds off once until every summary is back.
                if (p == 3 && !paused && phase_bytes >= 50)
                begin
                    wait_quiet();
                    paused = 1'b1;
                end
            end
        end

        wait_quiet();
        if (summary_q.size() != 0)
            report_mismatch("summaries never produced", 64'(summary_q.size()), 64'd0);
        if (mismatch_count == 0)
            $display("quic_header_parser_top verification clean");
        else
            $display("quic_header_parser_top verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5000000;
        $display("quic_header_parser_top verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/qhp_pkg.sv
rtl/quic_header_parser_top.sv
tb/tb.sv
